### hdl/sap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg
// Types, codes and microprogram of the stack allocator.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int NODE_BYTES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 32;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_UNKNOWN    = 3'd4
    } t_status;

    localparam logic [7:0] CFG_REGION_START = 8'd0;
    localparam logic [7:0] CFG_REGION_SIZE  = 8'd1;
    localparam logic [7:0] CFG_ALIGN_LOG2   = 8'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] req_size;
        logic [31:0] block_addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr_out;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  cfg_index;
        logic [31:0] cfg_data;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SET0,
        OP_SET1,
        OP_SET2,
        OP_SET3,
        OP_SET4,
        OP_SET5,
        OP_IDLE,
        OP_A_ROUND,
        OP_A_NEED,
        OP_A_HDR,
        OP_A_PUSH,
        OP_F_HDR,
        OP_F_READ,
        OP_F_NEXT,
        OP_F_KILL,
        OP_P_DEC,
        OP_P_READ,
        OP_P_TOP_RD,
        OP_P_TOP_SENT,
        OP_SET_IGN,
        OP_SET_NOSP,
        OP_SET_FULL,
        OP_SET_UNK,
        OP_RESP
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACC,
        C_IS_FREE,
        C_SZ_ZERO,
        C_NO_SPACE,
        C_FULL,
        C_P_ZERO,
        C_IDX_END,
        C_NO_MATCH,
        C_NOT_TOP,
        C_CNT_ZERO,
        C_RD_DEAD
    } t_cond;

    typedef logic [4:0] t_upc;

    localparam t_upc UA_SET0  = 5'd0;
    localparam t_upc UA_SET1  = 5'd1;
    localparam t_upc UA_SET2  = 5'd2;
    localparam t_upc UA_SET3  = 5'd3;
    localparam t_upc UA_SET4  = 5'd4;
    localparam t_upc UA_SET5  = 5'd5;
    localparam t_upc UA_IDLE  = 5'd6;
    localparam t_upc UA_DISP  = 5'd7;
    localparam t_upc UA_A0    = 5'd8;
    localparam t_upc UA_A1    = 5'd9;
    localparam t_upc UA_A2    = 5'd10;
    localparam t_upc UA_A3    = 5'd11;
    localparam t_upc UA_A4    = 5'd12;
    localparam t_upc UA_A5    = 5'd13;
    localparam t_upc UA_F0    = 5'd14;
    localparam t_upc UA_F1    = 5'd15;
    localparam t_upc UA_F2    = 5'd16;
    localparam t_upc UA_F3    = 5'd17;
    localparam t_upc UA_P0    = 5'd18;
    localparam t_upc UA_P1    = 5'd19;
    localparam t_upc UA_P2    = 5'd20;
    localparam t_upc UA_P3    = 5'd21;
    localparam t_upc UA_PSENT = 5'd22;
    localparam t_upc UA_IGN   = 5'd23;
    localparam t_upc UA_NOSP  = 5'd24;
    localparam t_upc UA_TFULL = 5'd25;
    localparam t_upc UA_UNK   = 5'd26;
    localparam t_upc UA_RESP  = 5'd27;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  tgt;
    } t_uword;

    typedef struct packed {
        logic no_acc;
        logic is_free;
        logic sz_zero;
        logic no_space;
        logic full;
        logic p_zero;
        logic idx_end;
        logic no_match;
        logic not_top;
        logic cnt_zero;
        logic rd_dead;
        logic out_busy;
        logic restart;
    } t_flags;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        unique case (upc)
            UA_SET0:  w = '{OP_SET0,       C_NEVER,    UA_SET0};
            UA_SET1:  w = '{OP_SET1,       C_NEVER,    UA_SET0};
            UA_SET2:  w = '{OP_SET2,       C_NEVER,    UA_SET0};
            UA_SET3:  w = '{OP_SET3,       C_NEVER,    UA_SET0};
            UA_SET4:  w = '{OP_SET4,       C_NEVER,    UA_SET0};
            UA_SET5:  w = '{OP_SET5,       C_NEVER,    UA_SET0};
            UA_IDLE:  w = '{OP_IDLE,       C_NO_ACC,   UA_IDLE};
            UA_DISP:  w = '{OP_NOP,        C_IS_FREE,  UA_F0};
            UA_A0:    w = '{OP_A_ROUND,    C_SZ_ZERO,  UA_IGN};
            UA_A1:    w = '{OP_A_NEED,     C_NEVER,    UA_SET0};
            UA_A2:    w = '{OP_NOP,        C_NO_SPACE, UA_NOSP};
            UA_A3:    w = '{OP_NOP,        C_FULL,     UA_TFULL};
            UA_A4:    w = '{OP_A_HDR,      C_NEVER,    UA_SET0};
            UA_A5:    w = '{OP_A_PUSH,     C_ALWAYS,   UA_RESP};
            UA_F0:    w = '{OP_F_HDR,      C_P_ZERO,   UA_IGN};
            UA_F1:    w = '{OP_F_READ,     C_IDX_END,  UA_UNK};
            UA_F2:    w = '{OP_F_NEXT,     C_NO_MATCH, UA_F1};
            UA_F3:    w = '{OP_F_KILL,     C_NOT_TOP,  UA_RESP};
            UA_P0:    w = '{OP_P_DEC,      C_NEVER,    UA_SET0};
            UA_P1:    w = '{OP_P_READ,     C_CNT_ZERO, UA_PSENT};
            UA_P2:    w = '{OP_NOP,        C_RD_DEAD,  UA_P0};
            UA_P3:    w = '{OP_P_TOP_RD,   C_ALWAYS,   UA_RESP};
            UA_PSENT: w = '{OP_P_TOP_SENT, C_ALWAYS,   UA_RESP};
            UA_IGN:   w = '{OP_SET_IGN,    C_ALWAYS,   UA_RESP};
            UA_NOSP:  w = '{OP_SET_NOSP,   C_ALWAYS,   UA_RESP};
            UA_TFULL: w = '{OP_SET_FULL,   C_ALWAYS,   UA_RESP};
            UA_UNK:   w = '{OP_SET_UNK,    C_ALWAYS,   UA_RESP};
            UA_RESP:  w = '{OP_RESP,       C_ALWAYS,   UA_IDLE};
            default:  w = '{OP_NOP,        C_ALWAYS,   UA_SET0};
        endcase
        return w;
    endfunction

endpackage

### hdl/sap_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_chan
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface sap_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/sap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/sap_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module sap_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sap_pkg::t_flags i_flags,
    output sap_pkg::t_uword o_uword
);
    import sap_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   take;

    always_comb begin
        uw = ucode(r_upc);
        unique case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_ACC:   take = i_flags.no_acc;
            C_IS_FREE:  take = i_flags.is_free;
            C_SZ_ZERO:  take = i_flags.sz_zero;
            C_NO_SPACE: take = i_flags.no_space;
            C_FULL:     take = i_flags.full;
            C_P_ZERO:   take = i_flags.p_zero;
            C_IDX_END:  take = i_flags.idx_end;
            C_NO_MATCH: take = i_flags.no_match;
            C_NOT_TOP:  take = i_flags.not_top;
            C_CNT_ZERO: take = i_flags.cnt_zero;
            C_RD_DEAD:  take = i_flags.rd_dead;
            default:    take = 1'b0;
        endcase

        if (i_flags.restart) begin
            n_upc = UA_SET0;
        end else if (uw.op == OP_RESP && i_flags.out_busy) begin
            n_upc = r_upc;
        end else if (take) begin
            n_upc = uw.tgt;
        end else begin
            n_upc = t_upc'(r_upc + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_SET0;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uw;

endmodule

### hdl/sap_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_dp
// Allocator datapath: config registers, address arithmetic, block table,
// and the result register, driven one control word per cycle.
// ----------------------------------------------------------------------------
module sap_dp #(
    parameter int MAX_BLOCKS = sap_pkg::MAX_BLOCKS_DEF,
    parameter int NODE_BYTES = sap_pkg::NODE_BYTES_DEF,
    parameter int ADDR_BITS  = sap_pkg::ADDR_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sap_pkg::t_uword i_uw,
    output sap_pkg::t_flags o_flags,
    sap_chan.sink           i_req,
    sap_chan.source         o_rsp,
    sap_chan.sink           i_cfg
);
    import sap_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int WW = ((ADDR_BITS > 35) ? ADDR_BITS : 35) + 1;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [WW-1:0] AMASK = WW'({AW{1'b1}});

    // config
    logic [31:0] r_start;
    logic [31:0] r_size;
    logic [3:0]  r_alog;

    // setup results
    logic [WW-1:0] r_sm;
    logic [WW-1:0] r_end;
    logic [WW-1:0] r_begin;
    logic [WW-1:0] r_node;
    logic [WW-1:0] r_sent;

    // per-request
    logic [WW-1:0] r_top;
    logic [WW-1:0] r_need;
    logic [WW-1:0] r_avail;
    logic [WW-1:0] r_hdr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_hit;
    logic          r_rtype;
    logic [31:0]   r_rsize;
    logic [31:0]   r_baddr;
    t_status       r_rstat;
    logic [WW-1:0] r_raddr;

    // result register
    logic          r_ovalid;
    t_status       r_ostat;
    logic [31:0]   r_oaddr;

    logic [WW-1:0] amask;
    logic [WW-1:0] start_m;
    logic [WW-1:0] sum_b;
    logic          big_b;
    logic [CW-1:0] cnt_m1;
    logic          cfg_fire;
    logic          cfg_known;
    logic          req_fire;
    logic          out_busy;
    logic          load_out;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [AW:0]   ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [AW:0]   ram_rdata;
    logic          rd_live;
    logic [AW-1:0] rd_hdr;

    assign amask    = WW'((16'd1 << r_alog) - 16'd1);
    assign start_m  = WW'(r_start) & AMASK;
    assign sum_b    = r_sm + amask;
    assign big_b    = (amask <= AMASK) && (sum_b > AMASK);
    assign cnt_m1   = r_count - CW'(1);
    assign rd_live  = ram_rdata[AW];
    assign rd_hdr   = ram_rdata[AW-1:0];

    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign req_fire = i_req.valid && i_req.ready;
    assign out_busy = r_ovalid && !o_rsp.ready;
    assign load_out = (i_uw.op == OP_RESP) && !out_busy;

    always_comb begin
        case (i_cfg.data.cfg_index)
            CFG_REGION_START, CFG_REGION_SIZE, CFG_ALIGN_LOG2: cfg_known = 1'b1;
            default: cfg_known = 1'b0;
        endcase
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (i_uw.op == OP_IDLE) && !i_cfg.valid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = '{status: r_ostat, addr_out: r_oaddr};

    always_comb begin
        o_flags.no_acc   = !req_fire;
        o_flags.is_free  = r_rtype;
        o_flags.sz_zero  = (r_rsize == 32'd0);
        o_flags.no_space = (r_avail < r_need);
        o_flags.full     = (r_count >= CW'(MAX_BLOCKS));
        o_flags.p_zero   = (r_baddr == 32'd0);
        o_flags.idx_end  = (r_idx == r_count);
        o_flags.no_match = !(rd_live && (rd_hdr == r_hdr[AW-1:0]));
        o_flags.not_top  = ((CW'(r_hit) + CW'(1)) != r_count);
        o_flags.cnt_zero = (r_count == '0);
        o_flags.rd_dead  = !rd_live;
        o_flags.out_busy = out_busy;
        o_flags.restart  = cfg_fire && cfg_known;
    end

    // block table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[IW-1:0];
        ram_wdata = {1'b1, r_hdr[AW-1:0]};
        ram_re    = 1'b0;
        ram_raddr = r_idx[IW-1:0];
        unique case (i_uw.op)
            OP_A_PUSH: begin
                ram_we = 1'b1;
            end
            OP_F_KILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit;
                ram_wdata = {1'b0, rd_hdr};
            end
            OP_F_READ: begin
                ram_re = 1'b1;
            end
            OP_P_READ: begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    sap_ram #(
        .WIDTH (AW + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 32'd0;
            r_size   <= 32'd0;
            r_alog   <= 4'd3;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (i_cfg.data.cfg_index)
                    CFG_REGION_START: r_start <= i_cfg.data.cfg_data;
                    CFG_REGION_SIZE:  r_size  <= i_cfg.data.cfg_data;
                    CFG_ALIGN_LOG2:   r_alog  <= i_cfg.data.cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ostat <= r_rstat;
            r_oaddr <= 32'(r_raddr);
        end
        unique case (i_uw.op)
            OP_SET0: begin
                r_sm  <= start_m;
                r_end <= start_m + WW'(r_size);
            end
            OP_SET1: begin
                r_end  <= ((r_end > AMASK) ? AMASK : r_end) & ~amask;
                r_node <= (WW'(NODE_BYTES) + amask) & ~amask;
            end
            OP_SET2: begin
                r_begin <= big_b ? r_end : (sum_b & ~amask);
            end
            OP_SET3: begin
                if (r_begin > r_end) begin
                    r_begin <= r_end;
                end
            end
            OP_SET4: begin
                r_avail <= r_end - r_begin;
            end
            OP_SET5: begin
                r_sent  <= (r_avail < r_node) ? r_begin : (r_end - r_node);
                r_top   <= (r_avail < r_node) ? r_begin : (r_end - r_node);
                r_count <= '0;
            end
            OP_IDLE: begin
                if (req_fire) begin
                    r_rtype <= i_req.data.req_type;
                    r_rsize <= i_req.data.req_size;
                    r_baddr <= i_req.data.block_addr;
                end
            end
            OP_A_ROUND: begin
                r_need <= (WW'(r_rsize) + amask) & ~amask;
            end
            OP_A_NEED: begin
                r_need  <= r_need + r_node;
                r_avail <= r_top - r_begin;
            end
            OP_A_HDR: begin
                r_hdr <= r_top - r_need;
            end
            OP_A_PUSH: begin
                r_count <= r_count + CW'(1);
                r_top   <= r_hdr;
                r_rstat <= ST_OK;
                r_raddr <= (r_hdr + r_node) & AMASK;
            end
            OP_F_HDR: begin
                r_hdr <= (WW'(r_baddr) - r_node) & AMASK;
                r_idx <= '0;
            end
            OP_F_READ: begin
                r_hit <= r_idx[IW-1:0];
            end
            OP_F_NEXT: begin
                r_idx <= r_idx + CW'(1);
            end
            OP_F_KILL: begin
                r_rstat <= ST_OK;
                r_raddr <= '0;
            end
            OP_P_DEC: begin
                r_count <= cnt_m1;
            end
            OP_P_TOP_RD: begin
                r_top <= WW'(rd_hdr);
            end
            OP_P_TOP_SENT: begin
                r_top <= r_sent;
            end
            OP_SET_IGN: begin
                r_rstat <= ST_IGNORED;
                r_raddr <= '0;
            end
            OP_SET_NOSP: begin
                r_rstat <= ST_NO_SPACE;
                r_raddr <= '0;
            end
            OP_SET_FULL: begin
                r_rstat <= ST_TABLE_FULL;
                r_raddr <= '0;
            end
            OP_SET_UNK: begin
                r_rstat <= ST_UNKNOWN;
                r_raddr <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/stack_allocator_out_of_order_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_allocator_out_of_order_free
// Downward-growing stack allocator with out-of-order free over a region.
//
// Channels: i_req takes allocate/free requests, o_rsp returns one status and
// payload address per request, i_cfg writes region_start, region_size and
// align_log2 (index 0..2). Write configuration only while no request is open.
// A microcoded sequencer runs each request one at a time. From transfer on
// i_req to result in the output register, allocate rounds the size, adds the
// node size, checks space and table room and pushes the new header; it ends
// early when size is zero, on no space or on a full table. Free scans the
// block table for the header, marks it dead and, if it was on top, pops it
// and every dead block below; an unknown block and a null free end early.
// The scan reads the block table one entry at a time, from entry 0 up.
// After reset, and after a write to a known register, a setup pass computes
// the region bounds; i_req.ready stays low meanwhile and all blocks are
// forgotten. The result register holds while o_rsp is stalled; the next
// request is taken in the meantime and waits in its final step.
// ----------------------------------------------------------------------------
module stack_allocator_out_of_order_free #(
    parameter int MAX_BLOCKS = sap_pkg::MAX_BLOCKS_DEF,
    parameter int NODE_BYTES = sap_pkg::NODE_BYTES_DEF,
    parameter int ADDR_BITS  = sap_pkg::ADDR_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sap_chan.sink   i_req,
    sap_chan.source o_rsp,
    sap_chan.sink   i_cfg
);
    import sap_pkg::*;

    t_uword uw;
    t_flags flags;

    sap_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    sap_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .NODE_BYTES (NODE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uw    (uw),
        .o_flags (flags),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );

endmodule
